// ----- rtl/csim_pkg.sv -----
// Package for the cosine similarity engine: field widths, fixed-point
// constants, result mode and back end state encodings. No dependencies.
package csim_pkg;

	localparam int ELEM_PORT_W      = 16;
	localparam int RESULT_W         = 54;
	localparam int MODE_W           = 2;
	localparam int FRAC_BITS        = 30;  // Q.30 result
	localparam int LIM2_BITS        = 52;  // query-normalized result bound 2^52
	localparam int DEF_MAX_LENGTH   = 4096;
	localparam int DEF_ELEMENT_BITS = 16;
	localparam int QUEUE_DEPTH      = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_NORM  = 2'd0,
		MODE_DIST  = 2'd1,
		MODE_QNORM = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL_DEN,
		BK_MUL_NUM,
		BK_DIVIDE,
		BK_ROOT,
		BK_FINISH
	} back_state_t;

	// queue occupancy seen by the front and back end
	typedef struct packed {
		logic empty;
		logic room;
	} queue_status_t;

endpackage

// ----- rtl/csim_if.sv -----
// Request channel interfaces for the cosine similarity engine.
// Depends on csim_pkg for the field widths.
interface csim_in_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [csim_pkg::ELEM_PORT_W-1:0]    left_element;
	logic signed [csim_pkg::ELEM_PORT_W-1:0]    right_element;
	logic                                       element_last;

	modport source (output valid, left_element, right_element, element_last, input ready);
	modport sink   (input valid, left_element, right_element, element_last, output ready);
endinterface

interface csim_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [csim_pkg::RESULT_W-1:0]    result_value;
	logic                                    zero_norm;

	modport source (output valid, result_value, zero_norm, input ready);
	modport sink   (input valid, result_value, zero_norm, output ready);
endinterface

// ----- rtl/csim_front.sv -----
// Front end: resizes element pairs to ELEMENT_BITS, forms products, accumulates the
// saturating dot product and squared norms, queues the sums on the last pair.
// Depends on csim_pkg and csim_if.
module csim_front #(
	parameter int MAX_LENGTH   = csim_pkg::DEF_MAX_LENGTH,
	parameter int ELEMENT_BITS = csim_pkg::DEF_ELEMENT_BITS,
	parameter int SUM_W        = 43
) (
	input  logic                     clk,
	input  logic                     arst_n,
	csim_in_if.sink                  in_ch,
	input  csim_pkg::queue_status_t  qstat,
	output logic                     push,
	output logic [3*SUM_W:0]         push_data
);
	import csim_pkg::*;

	localparam int PW = 2 * ELEMENT_BITS;
	localparam logic [SUM_W-1:0] LIMIT = SUM_W'(MAX_LENGTH) << (PW - 2);

	logic signed [ELEMENT_BITS-1:0] a_e, b_e;
	logic signed [PW-1:0]           ab, aa, bb;

	logic                  valid_s1, last_s1;
	logic signed [PW-1:0]  ab_s1;
	logic [PW-2:0]         aa_s1, bb_s1;

	logic signed [SUM_W:0] dot_q;
	logic [SUM_W-1:0]      n1_q, n2_q;

	logic signed [SUM_W+1:0] d_wide;
	logic [SUM_W:0]          n1_wide, n2_wide;
	logic signed [SUM_W:0]   d_nx;
	logic [SUM_W-1:0]        n1_nx, n2_nx;

	assign a_e = ELEMENT_BITS'(in_ch.left_element);
	assign b_e = ELEMENT_BITS'(in_ch.right_element);
	assign ab  = a_e * b_e;
	assign aa  = a_e * a_e;
	assign bb  = b_e * b_e;

	// one slot is held back for a last pair still in stage 1
	assign in_ch.ready = qstat.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_ch.valid && in_ch.ready;
		end
	end

	always_ff @(posedge clk) begin
		ab_s1   <= ab;
		aa_s1   <= aa[PW-2:0];
		bb_s1   <= bb[PW-2:0];
		last_s1 <= in_ch.element_last;
	end

	always_comb begin
		d_wide  = (SUM_W+2)'(dot_q) + (SUM_W+2)'(ab_s1);
		n1_wide = (SUM_W+1)'(n1_q) + (SUM_W+1)'(aa_s1);
		n2_wide = (SUM_W+1)'(n2_q) + (SUM_W+1)'(bb_s1);
		if (d_wide > $signed({2'b00, LIMIT}))
			d_nx = $signed({1'b0, LIMIT});
		else if (d_wide < -$signed({2'b00, LIMIT}))
			d_nx = -$signed({1'b0, LIMIT});
		else
			d_nx = d_wide[SUM_W:0];
		n1_nx = (n1_wide > {1'b0, LIMIT}) ? LIMIT : n1_wide[SUM_W-1:0];
		n2_nx = (n2_wide > {1'b0, LIMIT}) ? LIMIT : n2_wide[SUM_W-1:0];
	end

	assign push      = valid_s1 && last_s1;
	assign push_data = {d_nx, n1_nx, n2_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			n1_q  <= '0;
			n2_q  <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				dot_q <= '0;
				n1_q  <= '0;
				n2_q  <= '0;
			end else begin
				dot_q <= d_nx;
				n1_q  <= n1_nx;
				n2_q  <= n2_nx;
			end
		end
	end

endmodule

// ----- rtl/csim_fifo.sv -----
// Short queue of finished sums between front and back end.
// Depends on csim_pkg.
module csim_fifo #(
	parameter int W     = 130,
	parameter int DEPTH = csim_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [W-1:0]            din,
	input  logic                    pop,
	output logic [W-1:0]            dout,
	output csim_pkg::queue_status_t qstat
);
	import csim_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign dout        = mem[rd_q];
	assign qstat.empty = (cnt_q == '0);
	assign qstat.room  = (cnt_q < (AW+1)'(DEPTH - 1));

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// ----- rtl/csim_back.sv -----
// Back end: shift-add multiplier, restoring divider and restoring square
// root, one bit per cycle, then mode post-processing into the output register.
// Depends on csim_pkg and csim_if.
module csim_back #(
	parameter int SUM_W = 43
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  csim_pkg::mode_t         mode,
	input  csim_pkg::queue_status_t qstat,
	input  logic [3*SUM_W:0]        qdata,
	output logic                    pop,
	csim_out_if.source              out_ch
);
	import csim_pkg::*;

	localparam int DEN_W = 2 * SUM_W;
	localparam int NUM_W = DEN_W + 2 * FRAC_BITS;
	localparam int QW    = 2 * LIM2_BITS + 2;
	localparam int RT_W  = QW / 2;
	localparam int CW    = $clog2(NUM_W);
	localparam logic [RT_W-1:0] ONE_Q = RT_W'(1) << FRAC_BITS;

	back_state_t state_q, state_nx;

	logic signed [SUM_W:0] q_dot;
	logic [SUM_W-1:0]      q_n1, q_n2, q_mag;
	logic                  m2, n1z, n2z, special;

	logic [CW-1:0]      cnt_q;
	logic               mode2_q, dist_q, neg_q, zero_q;
	logic [SUM_W-1:0]   mag_in_q;
	logic [DEN_W-1:0]   mul_a_q, prod_q, den_q, prod_nx;
	logic [SUM_W-1:0]   mul_b_q;
	logic [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]   rem_q, rem_nx;
	logic [DEN_W:0]     rem_sh;
	logic [QW-1:0]      quo_q, quo_nx, sq_q, lim;
	logic               ovf_q, ovf_nx;
	logic [RT_W+1:0]    srem_q, srem_nx;
	logic [RT_W+2:0]    s_sh, s_trial;
	logic [RT_W-1:0]    root_q, root_nx, res_mag_q, fmag;
	logic               fneg;
	logic               out_valid_q;
	logic [RESULT_W-1:0] out_value_q;
	logic               out_zero_q;

	assign {q_dot, q_n1, q_n2} = qdata;
	assign q_mag   = q_dot[SUM_W] ? SUM_W'(-q_dot) : q_dot[SUM_W-1:0];
	assign m2      = (mode == MODE_QNORM);
	assign n1z     = (q_n1 == '0);
	assign n2z     = (q_n2 == '0);
	assign special = m2 ? n2z : (n1z || n2z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		pop      = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!qstat.empty && !out_valid_q) begin
					pop = 1'b1;
					if (special)
						state_nx = BK_FINISH;
					else if (m2)
						state_nx = BK_MUL_NUM;
					else
						state_nx = BK_MUL_DEN;
				end
			end
			BK_MUL_DEN: if (cnt_q == CW'(SUM_W - 1)) state_nx = BK_MUL_NUM;
			BK_MUL_NUM: if (cnt_q == CW'(SUM_W - 1)) state_nx = BK_DIVIDE;
			BK_DIVIDE:  if (cnt_q == CW'(NUM_W - 1)) state_nx = BK_ROOT;
			BK_ROOT:    if (cnt_q == CW'(RT_W - 1))  state_nx = BK_FINISH;
			BK_FINISH:  state_nx = BK_IDLE;
			default:    state_nx = BK_IDLE;
		endcase
	end

	// one step of each serial unit
	always_comb begin
		prod_nx = prod_q + (mul_b_q[0] ? mul_a_q : '0);

		rem_sh = {rem_q, num_q[NUM_W-1]};
		if (rem_sh >= {1'b0, den_q}) begin
			rem_nx = DEN_W'(rem_sh - {1'b0, den_q});
			quo_nx = {quo_q[QW-2:0], 1'b1};
		end else begin
			rem_nx = rem_sh[DEN_W-1:0];
			quo_nx = {quo_q[QW-2:0], 1'b0};
		end
		ovf_nx = ovf_q || quo_q[QW-1];
		lim    = mode2_q ? (QW'(1) << (2 * LIM2_BITS)) : (QW'(1) << (2 * FRAC_BITS));

		s_sh    = {srem_q[RT_W:0], sq_q[QW-1:QW-2]};
		s_trial = {1'b0, root_q, 2'b01};
		if (s_sh >= s_trial) begin
			srem_nx = (RT_W+2)'(s_sh - s_trial);
			root_nx = {root_q[RT_W-2:0], 1'b1};
		end else begin
			srem_nx = s_sh[RT_W+1:0];
			root_nx = {root_q[RT_W-2:0], 1'b0};
		end

		// distance is 1 minus the signed similarity
		fmag = res_mag_q;
		fneg = neg_q;
		if (dist_q) begin
			fmag = neg_q ? ONE_Q + res_mag_q : ONE_Q - res_mag_q;
			fneg = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (state_nx != state_q)
			cnt_q <= '0;
		else
			cnt_q <= cnt_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				mode2_q   <= m2;
				dist_q    <= (mode == MODE_DIST);
				neg_q     <= q_dot[SUM_W] && !special;
				zero_q    <= special;
				mag_in_q  <= q_mag;
				prod_q    <= '0;
				den_q     <= DEN_W'(q_n2);
				res_mag_q <= (!m2 && n1z && n2z) ? ONE_Q : '0;
				if (m2) begin
					mul_a_q <= DEN_W'(q_mag);
					mul_b_q <= q_mag;
				end else begin
					mul_a_q <= DEN_W'(q_n1);
					mul_b_q <= q_n2;
				end
			end
			BK_MUL_DEN: begin
				if (cnt_q == CW'(SUM_W - 1)) begin
					den_q   <= prod_nx;
					prod_q  <= '0;
					mul_a_q <= DEN_W'(mag_in_q);
					mul_b_q <= mag_in_q;
				end else begin
					prod_q  <= prod_nx;
					mul_a_q <= mul_a_q << 1;
					mul_b_q <= mul_b_q >> 1;
				end
			end
			BK_MUL_NUM: begin
				prod_q  <= prod_nx;
				mul_a_q <= mul_a_q << 1;
				mul_b_q <= mul_b_q >> 1;
				if (cnt_q == CW'(SUM_W - 1)) begin
					num_q <= {prod_nx, {(2 * FRAC_BITS){1'b0}}};
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			BK_DIVIDE: begin
				num_q <= num_q << 1;
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				ovf_q <= ovf_nx;
				if (cnt_q == CW'(NUM_W - 1)) begin
					sq_q   <= (ovf_nx || quo_nx > lim) ? lim : quo_nx;
					srem_q <= '0;
					root_q <= '0;
				end
			end
			BK_ROOT: begin
				sq_q   <= sq_q << 2;
				srem_q <= srem_nx;
				root_q <= root_nx;
				if (cnt_q == CW'(RT_W - 1))
					res_mag_q <= root_nx;
			end
			BK_FINISH: begin
				out_value_q <= (fneg && fmag != '0) ? -RESULT_W'(fmag) : RESULT_W'(fmag);
				out_zero_q  <= zero_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == BK_FINISH)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.result_value = out_value_q;
	assign out_ch.zero_norm    = out_zero_q;

endmodule

// ----- rtl/cosine_similarity_engine.sv -----
// Top level of the cosine similarity engine: mode register, front end,
// sum queue and back end. Depends on csim_pkg, csim_if and the csim_* modules.
//
//  channel  | dir | handshake    | request
//  in_ch    | in  | valid/ready  | left_element, right_element, element_last
//  out_ch   | out | valid/ready  | result_value (Q.30), zero_norm
//  cfg      | in  | cfg_we       | cfg_wdata -> result_mode
//
// Element pairs are taken one per cycle while the queue has room; the sums
// pass through the stage 1 register into the queue after the last pair. The
// back end pops the sums, runs shift-add multiplies (two in modes 0 and 1,
// one in mode 2), its one-bit-per-cycle divider and root unit, then a finish
// step; special cases go from the pop straight to the finish step.
// Up to four finished vectors wait in the queue; input stalls once three are held.
// arst_n clears sums, queue, state and the mode register.
module cosine_similarity_engine #(
	parameter int MAX_LENGTH   = csim_pkg::DEF_MAX_LENGTH,
	parameter int ELEMENT_BITS = csim_pkg::DEF_ELEMENT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [csim_pkg::MODE_W-1:0]   cfg_wdata,
	csim_in_if.sink                       in_ch,
	csim_out_if.source                    out_ch
);
	import csim_pkg::*;

	localparam int SUM_W = $clog2(MAX_LENGTH + 1) + 2 * ELEMENT_BITS - 2;
	localparam int QD_W  = 3 * SUM_W + 1;

	logic [MODE_W-1:0] mode_q;
	logic              push, pop;
	logic [QD_W-1:0]   push_data, qdata;
	queue_status_t     qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_NORM;
		else if (cfg_we)
			mode_q <= cfg_wdata;
	end

	csim_front #(
		.MAX_LENGTH   (MAX_LENGTH),
		.ELEMENT_BITS (ELEMENT_BITS),
		.SUM_W        (SUM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	csim_fifo #(
		.W     (QD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.pop    (pop),
		.dout   (qdata),
		.qstat  (qstat)
	);

	csim_back #(
		.SUM_W (SUM_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (mode_t'(mode_q)),
		.qstat  (qstat),
		.qdata  (qdata),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

// ----- rtl/csim_checker.sv -----
// Port-level checks for the cosine similarity engine, bound to the top level.
// Depends on csim_pkg.
module csim_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [csim_pkg::RESULT_W-1:0]  result_value,
	input logic                                  zero_norm
);
	import csim_pkg::*;

	localparam logic signed [RESULT_W-1:0] BOUND = RESULT_W'(1) << LIM2_BITS;
	localparam logic signed [RESULT_W-1:0] ONE_R = RESULT_W'(1) << FRAC_BITS;

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(zero_norm))
		else $error("stalled result dropped or changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_value <= BOUND && result_value >= -BOUND)
		else $error("result beyond 2^52");

	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_norm |-> result_value == '0 || result_value == ONE_R)
		else $error("zero norm result is neither 0 nor 1");

endmodule

bind cosine_similarity_engine csim_checker u_csim_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.result_value (out_ch.result_value),
	.zero_norm    (out_ch.zero_norm)
);

// ----- bench/tb_cosine_similarity_engine.sv -----
// Self-checking bench for cosine_similarity_engine: a table of directed vectors, then random
// vectors under each result mode, checked against an exact integer model of the measures.
// Depends on csim_pkg, csim_if and the RTL of the engine.
module tb_cosine_similarity_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import csim_pkg::*;

	localparam longint SUM_BOUND  = longint'(DEF_MAX_LENGTH) << (2*DEF_ELEMENT_BITS - 2);
	localparam int     STALL_LIMIT = 20000;
	localparam int     DRAIN_WAIT  = 500;

	typedef logic signed [ELEM_PORT_W-1:0] elem_t;
	typedef logic signed [RESULT_W-1:0]    res_t;
	typedef logic [255:0]                  wide_t;

	typedef struct {
		res_t value;
		logic zero;
	} measure_t;

	typedef struct {
		mode_t mode;
		elem_t left;
		elem_t right;
		logic  last;
		bit    typed;
		res_t  value;
		logic  zero;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [MODE_W-1:0] cfg_wdata = '0;

	csim_in_if  in_ch();
	csim_out_if out_ch();

	cosine_similarity_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always #1 clk = ~clk;

	measure_t pending_results[$];
	longint   acc_dot, acc_left, acc_right;
	logic [MODE_W-1:0] cur_mode;
	int  errors = 0;
	int  idle_cycles = 0;
	bit  quiet = 1'b0;
	int  items_sent = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.left_element = '0;
		in_ch.right_element = '0;
		in_ch.element_last = 1'b0;
		out_ch.ready = 1'b0;
	end

	// largest r in [0, hi] with r*r*den <= num
	function automatic longint unsigned root_search(wide_t num, wide_t den,
			longint unsigned hi);
		longint unsigned lo, mid;
		wide_t m;
		lo = 0;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			m = wide_t'(mid);
			if (m * m * den <= num) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic measure_t cosine_measure(longint dot, longint nl, longint nr,
			logic [MODE_W-1:0] mode);
		measure_t r;
		bit neg;
		longint unsigned mag;
		wide_t num;
		neg = dot < 0;
		mag = neg ? longint'(-dot) : dot;
		num = (wide_t'(mag) * wide_t'(mag)) << 60;
		if (mode == MODE_QNORM) begin
			r.zero = nr == 0;
			mag = r.zero ? 0 : root_search(num, wide_t'(nr), 64'd1 << LIM2_BITS);
		end else begin
			r.zero = nl == 0 || nr == 0;
			if (nl == 0 && nr == 0) begin
				mag = 64'd1 << FRAC_BITS;
				neg = 1'b0;
			end else if (r.zero) begin
				mag = 0;
			end else begin
				mag = root_search(num, wide_t'(nl) * wide_t'(nr), 64'd1 << FRAC_BITS);
			end
			if (mode == MODE_DIST) begin
				mag = neg ? (64'd1 << FRAC_BITS) + mag : (64'd1 << FRAC_BITS) - mag;
				neg = 1'b0;
			end
		end
		r.value = neg ? -res_t'(mag) : res_t'(mag);
		return r;
	endfunction

	function automatic longint clamp_sum(longint v, longint lo);
		if (v > SUM_BOUND) return SUM_BOUND;
		if (v < lo) return lo;
		return v;
	endfunction

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_mode(logic [MODE_W-1:0] m);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_mode = m;
	endtask

	// one request; valid stays high across back-to-back requests
	task automatic send_pair(elem_t l, elem_t r, logic last, bit typed = 0,
			res_t tv = '0, logic tz = 1'b0);
		longint a, b;
		measure_t m;
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 18);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.left_element <= l;
		in_ch.right_element <= r;
		in_ch.element_last <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
		a = longint'(l);
		b = longint'(r);
		acc_dot = clamp_sum(acc_dot + a * b, -SUM_BOUND);
		acc_left = clamp_sum(acc_left + a * a, 0);
		acc_right = clamp_sum(acc_right + b * b, 0);
		if (last) begin
			m = cosine_measure(acc_dot, acc_left, acc_right, cur_mode);
			if (typed) begin
				m.value = tv;
				m.zero = tz;
			end
			pending_results.push_back(m);
			acc_dot = 0;
			acc_left = 0;
			acc_right = 0;
		end
	endtask

	task automatic send_vector();
		int len, kind;
		elem_t l, r;
		elem_t ext[4];
		ext = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
		kind = $urandom_range(0, 9);
		for (int i = 0; i < len; i++) begin
			l = elem_t'($urandom);
			r = elem_t'($urandom);
			case (kind)
				5, 6: begin
					l = elem_t'(int'($urandom_range(0, 16)) - 8);
					r = elem_t'(int'($urandom_range(0, 16)) - 8);
				end
				7: begin
					l = ext[$urandom_range(0, 3)];
					r = ext[$urandom_range(0, 3)];
				end
				8: r = '0;
				9: l = '0;
				default: ;
			endcase
			send_pair(l, r, i == len - 1);
		end
	endtask

	vec_row_t directed[$] = '{
		'{MODE_NORM, 16'sd0, 16'sd0, 1'b1, 1, res_t'(64'd1 << FRAC_BITS), 1'b1},
		'{MODE_NORM, 16'sd0, 16'sd5, 1'b1, 1, '0, 1'b1},
		'{MODE_NORM, 16'sd5, 16'sd0, 1'b1, 1, '0, 1'b1},
		'{MODE_NORM, -16'sd32768, -16'sd32768, 1'b1, 1, res_t'(64'd1 << FRAC_BITS), 1'b0},
		'{MODE_NORM, 16'sd32767, -16'sd32768, 1'b1, 1, -res_t'(64'd1 << FRAC_BITS), 1'b0},
		'{MODE_NORM, 16'sd3, 16'sd4, 1'b0, 0, '0, 1'b0},
		'{MODE_NORM, -16'sd7, 16'sd2, 1'b0, 0, '0, 1'b0},
		'{MODE_NORM, 16'sd1, 16'sd1, 1'b1, 0, '0, 1'b0},
		'{MODE_DIST, 16'sd0, 16'sd0, 1'b1, 1, '0, 1'b1},
		'{MODE_DIST, 16'sd9, 16'sd0, 1'b1, 1, res_t'(64'd1 << FRAC_BITS), 1'b1},
		'{MODE_DIST, 16'sd32767, -16'sd32768, 1'b1, 1, res_t'(64'd2 << FRAC_BITS), 1'b0},
		'{MODE_DIST, 16'sd1, 16'sd2, 1'b0, 0, '0, 1'b0},
		'{MODE_DIST, 16'sd3, -16'sd1, 1'b1, 0, '0, 1'b0},
		'{MODE_QNORM, 16'sd5, 16'sd0, 1'b1, 1, '0, 1'b1},
		'{MODE_QNORM, 16'sd0, 16'sd7, 1'b1, 1, '0, 1'b0},
		'{MODE_QNORM, 16'sd3, 16'sd4, 1'b1, 1, res_t'(64'd3 << FRAC_BITS), 1'b0},
		'{MODE_QNORM, -16'sd32768, 16'sd32767, 1'b1, 0, '0, 1'b0},
		'{MODE_QNORM, 16'sd32767, 16'sd1, 1'b0, 0, '0, 1'b0},
		'{MODE_QNORM, -16'sd5, -16'sd3, 1'b1, 0, '0, 1'b0}
	};

	// results side: random backpressure bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 18);
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		measure_t e;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result value=%0d zero_norm=%0b", $realtime,
					out_ch.result_value, out_ch.zero_norm);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (out_ch.result_value !== e.value) begin
					$display("%0t: result_value expected %0d actual %0d", $realtime,
						e.value, out_ch.result_value);
					errors++;
				end
				if (out_ch.zero_norm !== e.zero) begin
					$display("%0t: zero_norm expected %0b actual %0b", $realtime,
						e.zero, out_ch.zero_norm);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any request moving
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [MODE_W-1:0] phase_modes[7];
		phase_modes = '{MODE_NORM, MODE_DIST, MODE_QNORM, 2'd3, MODE_QNORM, MODE_DIST, MODE_NORM};
		acc_dot = 0;
		acc_left = 0;
		acc_right = 0;
		cur_mode = MODE_NORM;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].mode != cur_mode) begin
				in_ch.valid <= 1'b0;
				write_mode(directed[i].mode);
			end
			send_pair(directed[i].left, directed[i].right, directed[i].last,
				directed[i].typed, directed[i].value, directed[i].zero);
		end

		foreach (phase_modes[p]) begin
			in_ch.valid <= 1'b0;
			write_mode(phase_modes[p]);
			if (p == 6) quiet = 1'b1;
			for (int start = items_sent; items_sent - start < 125; )
				send_vector();
		end
		in_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/csim_pkg.sv
rtl/csim_if.sv
rtl/csim_front.sv
rtl/csim_fifo.sv
rtl/csim_back.sv
rtl/cosine_similarity_engine.sv
rtl/csim_checker.sv
bench/tb_cosine_similarity_engine.sv
